### hdl/aqss_pkg.sv
// ============================================================================
// aqss_pkg
// Shared types and constants for the quiet-region spectrum smoother.
// ============================================================================
package aqss_pkg;

  // Longest frame; the bin at MAX_BINS-1 always closes the frame.
  localparam int MAX_BINS = 1024;
  localparam int POS_W    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

  // Widths of the internal arithmetic.
  localparam int DIFF_W = 21;  // weighted tap sum minus k times the center
  localparam int Q_W    = 17;  // weight, unsigned Q1.16
  localparam int NUM_W  = 39;  // diff times weight
  localparam int U_W    = 23;  // biased quotient input for the divide by ten
  localparam int E10_W  = 20;  // quotient of the divide by ten

  // dB thresholds in Q7.8.
  localparam int VIEW_OFFSET = 7680;  // 30 dB below the view top
  localparam int T_SAT       = 8960;  // 35 dB
  localparam int SPAN_QUIET  = 3584;  // 14 dB

  // Weight limits.
  localparam int Q_ONE      = 65536;
  localparam int Q_PASS_MAX = 65;     // q * 1000 <= 65536

  // Reciprocals for the constant divides.
  localparam int M35    = (1 << 27) / 35;
  localparam int M7     = (1 << 24) / 7;
  localparam int M10    = (1 << 27) / 10;
  localparam int Y_BIAS = 10 * (1 << 19);
  localparam int Y_UNBIAS = 1 << 19;

  // Rounding offsets for the two blend divisors.
  localparam int HALF_K4  = 4 * 32768;
  localparam int HALF_K10 = 10 * 32768;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_K4,
    KIND_K10
  } aqss_kind_t;

  typedef struct packed {
    logic signed [15:0] bin_db;
    logic               frame_last;
  } aqss_in_t;

  typedef struct packed {
    logic signed [15:0] smoothed_db;
    logic               out_last;
  } aqss_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       shift;        // accepted input beat enters the window
    logic       step_window;  // max, min, tap sum, weight terms
    logic       step_recip;   // reciprocal products
    logic       step_weight;  // quotient correction and weight
    logic       step_mult;    // diff times weight
    logic       step_scale;   // divide by k
    logic       emit;         // load the output register
    logic [1:0] offset;       // distance of the result bin from the newest bin
    logic [2:0] pclip;        // bins before the newest one, clipped at four
  } aqss_cmd_t;

  typedef struct packed {
    logic out_free;
  } aqss_status_t;

endpackage

### hdl/aqss_ctrl.sv
// ============================================================================
// aqss_ctrl
// Sequencer: takes input beats, tracks the frame position and runs each
// result through the datapath steps.
// ============================================================================
module aqss_ctrl
  import aqss_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         frame_last,
  output logic         in_ready,
  input  aqss_status_t status,
  output aqss_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } state_t;

  state_t           state;
  logic [2:0]       step;
  logic [POS_W-1:0] pos;
  logic             cur_last;
  logic [1:0]       offset;
  logic [2:0]       pclip;

  logic accept;
  logic last_now;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign last_now = frame_last || (pos == POS_W'(MAX_BINS - 1));

  // Commands decoded from the sequencer state.
  always_comb begin
    cmd             = '0;
    cmd.shift       = accept;
    cmd.offset      = offset;
    cmd.pclip       = pclip;
    cmd.step_window = (state == ST_CALC) && (step == 3'd0);
    cmd.step_recip  = (state == ST_CALC) && (step == 3'd1);
    cmd.step_weight = (state == ST_CALC) && (step == 3'd2);
    cmd.step_mult   = (state == ST_CALC) && (step == 3'd3);
    cmd.step_scale  = (state == ST_CALC) && (step == 3'd4);
    cmd.emit        = (state == ST_EMIT) && status.out_free;
  end

  // State and position registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step     <= 3'd0;
      pos      <= '0;
      cur_last <= 1'b0;
      offset   <= 2'd0;
      pclip    <= 3'd0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cur_last <= last_now;
            pclip    <= (int'(pos) >= 4) ? 3'd4 : 3'(pos);
            pos      <= last_now ? '0 : pos + 1'b1;
            step     <= 3'd0;
            // The first result of this beat, if it yields any.
            if (int'(pos) >= 2) begin
              offset <= 2'd2;
              state  <= ST_CALC;
            end else if (last_now) begin
              offset <= (int'(pos) >= 1) ? 2'd1 : 2'd0;
              state  <= ST_CALC;
            end
          end
        end
        ST_CALC: begin
          if (step == 3'd4) begin
            state <= ST_EMIT;
          end else begin
            step <= step + 3'd1;
          end
        end
        ST_EMIT: begin
          if (status.out_free) begin
            step <= 3'd0;
            // A closing beat flushes the two younger bins as well.
            if (offset == 2'd2 && cur_last) begin
              offset <= 2'd1;
              state  <= ST_CALC;
            end else if (offset == 2'd1) begin
              offset <= 2'd0;
              state  <= ST_CALC;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/aqss_datapath.sv
// ============================================================================
// aqss_datapath
// Bin window, weight computation, blend and output register.
// ============================================================================
module aqss_datapath
  import aqss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  aqss_cmd_t          cmd,
  input  logic signed [15:0] bin_db,
  input  logic               cfg_we,
  input  logic signed [15:0] cfg_data,
  output aqss_status_t       status,
  output logic               out_valid,
  input  logic               out_ready,
  output aqss_out_t          out_data
);

  logic signed [15:0] win [5];
  logic signed [15:0] view_top;

  // Window step results.
  logic signed [15:0]       a_c;
  aqss_kind_t               a_kind;
  logic signed [DIFF_W-1:0] a_diff;
  logic [13:0]              a_t;
  logic                     a_tpos;
  logic                     a_tsat;
  logic [11:0]              a_x;

  // Reciprocal and weight step results.
  logic [Q_W-1:0] b_e1;
  logic [Q_W-1:0] b_e2;
  logic [Q_W-1:0] c_q;
  logic           c_pass;

  // Multiply and scale step results.
  logic signed [NUM_W-1:0]  d_num;
  logic signed [DIFF_W-1:0] e_y4;
  logic [U_W-1:0]           e_u;
  logic [E10_W-1:0]         e_e10;

  // Window registers and view top register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++) begin
        win[i] <= '0;
      end
      view_top <= '0;
    end else begin
      if (cmd.shift) begin
        for (int i = 0; i < 4; i++) begin
          win[i] <= win[i+1];
        end
        win[4] <= bin_db;
      end
      if (cfg_we) begin
        view_top <= cfg_data;
      end
    end
  end

  // Window step: extremes over the clipped window, tap sum and weight terms.
  logic [2:0]               ci;
  logic signed [15:0]       cen;
  logic signed [15:0]       mx;
  logic signed [15:0]       mn;
  logic [4:0]               tap_ok;
  aqss_kind_t               kind;
  logic signed [DIFF_W-1:0] diff;
  logic signed [17:0]       t_full;
  logic [16:0]              span;
  logic [11:0]              x_val;

  always_comb begin
    ci  = 3'd4 - {1'b0, cmd.offset};
    cen = win[ci];
    for (int i = 0; i < 5; i++) begin
      tap_ok[i] = (i + int'(cmd.pclip) >= 4) && (i + 2 >= int'(ci)) && (i <= int'(ci) + 2);
    end
    mx = cen;
    mn = cen;
    for (int i = 0; i < 5; i++) begin
      if (tap_ok[i] && win[i] > mx) mx = win[i];
      if (tap_ok[i] && win[i] < mn) mn = win[i];
    end

    // Blend kind follows from how far the center sits from the frame edges.
    kind = KIND_PASS;
    diff = '0;
    if (cmd.offset == 2'd2 && cmd.pclip == 3'd4) begin
      kind = KIND_K10;
      diff = DIFF_W'(win[0]) + (DIFF_W'(win[1]) <<< 1) + (DIFF_W'(win[3]) <<< 1)
           + DIFF_W'(win[4]) - DIFF_W'(win[2]) * DIFF_W'(6);
    end else if (cmd.offset == 2'd2 && cmd.pclip >= 3'd3) begin
      kind = KIND_K4;
      diff = DIFF_W'(win[1]) + DIFF_W'(win[3]) - (DIFF_W'(win[2]) <<< 1);
    end else if (cmd.offset == 2'd1 && cmd.pclip >= 3'd2) begin
      kind = KIND_K4;
      diff = DIFF_W'(win[2]) + DIFF_W'(win[4]) - (DIFF_W'(win[3]) <<< 1);
    end

    t_full = 18'(view_top) - 18'(VIEW_OFFSET) - 18'(mx);
    span   = 17'(17'(mx) - 17'(mn));
    x_val  = (span < 17'(SPAN_QUIET)) ? 12'(17'(SPAN_QUIET) - span) : 12'd0;
  end

  // Reciprocal products for the divides by 35 and 7.
  logic [35:0] prod1;
  logic [33:0] prod2;
  assign prod1 = {22'b0, a_t} * 36'(M35);
  assign prod2 = {22'b0, a_x} * 34'(M7);

  // Quotient correction: the estimates are low by at most one.
  logic [21:0]    r1;
  logic [18:0]    r2;
  logic [Q_W-1:0] q1;
  logic [Q_W-1:0] q2;
  logic [Q_W-1:0] q;

  always_comb begin
    r1 = {a_t, 8'b0} - 22'(b_e1 * 22'd35);
    r2 = {a_x, 7'b0} - 19'(b_e2 * 19'd7);
    if (a_tsat) begin
      q1 = Q_W'(Q_ONE);
    end else if (a_tpos) begin
      q1 = (r1 >= 22'd35) ? b_e1 + 1'b1 : b_e1;
    end else begin
      q1 = '0;
    end
    if (a_x != 12'd0) begin
      q2 = (r2 >= 19'd7) ? b_e2 + 1'b1 : b_e2;
    end else begin
      q2 = '0;
    end
    q = (q1 > q2) ? q1 : q2;
  end

  // Multiply operands.
  logic signed [NUM_W-1:0] diff_x;
  logic signed [NUM_W-1:0] q_x;
  assign diff_x = NUM_W'(a_diff);
  assign q_x    = NUM_W'(signed'({1'b0, c_q}));

  // Scale step: shift for k of four, biased reciprocal for k of ten.
  logic signed [NUM_W-1:0] s4;
  logic signed [NUM_W-1:0] s10;
  logic signed [U_W-1:0]   y10_raw;
  logic [U_W:0]            u_wide;
  logic [U_W-1:0]          u_val;
  logic [46:0]             prod10;

  always_comb begin
    s4      = d_num + NUM_W'(HALF_K4);
    s10     = d_num + NUM_W'(HALF_K10);
    y10_raw = s10[NUM_W-1:16];
    u_wide  = (U_W+1)'(y10_raw) + (U_W+1)'(Y_BIAS);
    u_val   = u_wide[U_W-1:0];
    prod10  = {24'b0, u_val} * 47'(M10);
  end

  // Final correction, blend and saturation.
  logic [U_W-1:0]           r10;
  logic [E10_W-1:0]         f10;
  logic signed [DIFF_W-1:0] y10;
  logic signed [DIFF_W-1:0] ysel;
  logic signed [DIFF_W:0]   res;
  logic signed [15:0]       res_sat;

  always_comb begin
    r10  = e_u - U_W'({3'b0, e_e10} * U_W'(10));
    f10  = (r10 >= U_W'(10)) ? e_e10 + 1'b1 : e_e10;
    y10  = signed'({1'b0, f10}) - DIFF_W'(Y_UNBIAS);
    ysel = (a_kind == KIND_K10) ? y10 : e_y4;
    res  = (DIFF_W+1)'(a_c) + (DIFF_W+1)'(ysel);
    if (c_pass) begin
      res_sat = a_c;
    end else if (res > (DIFF_W+1)'(32767)) begin
      res_sat = 16'sh7fff;
    end else if (res < -(DIFF_W+1)'(32768)) begin
      res_sat = -16'sh8000;
    end else begin
      res_sat = res[15:0];
    end
  end

  // Step registers.
  always_ff @(posedge clk) begin
    if (cmd.step_window) begin
      a_c    <= cen;
      a_kind <= kind;
      a_diff <= diff;
      a_t    <= t_full[13:0];
      a_tpos <= (t_full > 18'sd0);
      a_tsat <= (t_full >= 18'(T_SAT));
      a_x    <= x_val;
    end
    if (cmd.step_recip) begin
      b_e1 <= prod1[35:19];
      b_e2 <= prod2[33:17];
    end
    if (cmd.step_weight) begin
      c_q    <= q;
      c_pass <= (a_kind == KIND_PASS) || (q <= Q_W'(Q_PASS_MAX));
    end
    if (cmd.step_mult) begin
      d_num <= NUM_W'(diff_x * q_x);
    end
    if (cmd.step_scale) begin
      e_y4  <= s4[NUM_W-1:18];
      e_u   <= u_val;
      e_e10 <= prod10[46:27];
    end
  end

  // Output register.
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.smoothed_db <= res_sat;
      out_data.out_last    <= (cmd.offset == 2'd0);
    end
  end

endmodule

### hdl/adaptive_quiet_spectrum_smoother.sv
// ============================================================================
// adaptive_quiet_spectrum_smoother
// Smooths quiet regions of a spectrum frame streamed as Q7.8 dB bins.
// ============================================================================
// Usage:
//   Input beats carry one bin (bin_db) and frame_last on the final bin of a
//   frame. Output beats carry one smoothed bin, with out_last on the final
//   result of the frame. Results trail the input by two bins; the closing
//   beat of a frame flushes the remaining results, up to three in all.
//   The configuration channel writes view_top_db; it is always ready. The
//   user is to write it only while the block holds no unfinished beat; the
//   block itself does not enforce this. Each result runs through five
//   datapath steps and one output load, one result at a time, so no new
//   input beat is accepted until every result of the current beat has
//   been loaded into the output register.
//   A waiting result sits in the output register while the next input beat
//   is taken; if the receiver stalls, the sequencer holds the next result
//   until the register frees up and input is paused meanwhile.
//   Reset clears the bin window, the frame position and view_top_db, and
//   drops any result not yet delivered.
// ============================================================================
module adaptive_quiet_spectrum_smoother
  import aqss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  aqss_in_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output aqss_out_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [15:0] cfg_data
);

  aqss_cmd_t    cmd;
  aqss_status_t status;

  assign cfg_ready = 1'b1;

  aqss_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .frame_last (in_data.frame_last),
    .in_ready   (in_ready),
    .status     (status),
    .cmd        (cmd)
  );

  aqss_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .bin_db    (in_data.bin_db),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### bench/adaptive_quiet_spectrum_smoother_test.sv
`timescale 1ns / 1ps
// ============================================================================
// adaptive_quiet_spectrum_smoother_test
// Self-checking bench for the quiet-region spectrum smoother. A scoreboard
// class keeps its own bin window, frame position and view top, predicts the
// smoothed bins for every accepted input beat and compares each output beat
// against the oldest prediction. Stimulus covers directed edge frames and
// random frames under several view-top settings, with random idling on both
// channels and one long receiver hold-off.
// ============================================================================
module adaptive_quiet_spectrum_smoother_test;
  import aqss_pkg::*;

  // Bench timing limits, in clock cycles, and the bin count per phase.
  localparam int STALL_LIMIT = 5000;  // cycles without any beat before giving up
  localparam int LONG_HOLD   = 200;   // long receiver hold-off
  localparam int SETTLE      = 40;    // quiet time before a register write
  localparam int PHASE_BINS  = 16;    // random bins per configuration phase

  // Kinds of random bin content.
  typedef enum int {
    MIX_FULL,   // any 16-bit value
    MIX_QUIET,  // narrow spread, below the 14 dB span limit
    MIX_NEAR,   // close to the 30 dB below-top threshold
    MIX_ANY     // a fresh pick of the above for every bin
  } bin_mix_t;

  // Scoreboard: predicts smoothed bins and checks the output beats.
  class smoother_scoreboard;
    logic signed [15:0] window [5];
    logic [10:0]        frame_pos;
    logic signed [15:0] view_top;
    aqss_out_t          smoothed_due [$];
    int                 mismatches;
    int                 results_seen;
    int                 bins_seen;
    int                 frames_seen;

    function new();
      for (int i = 0; i < 5; i++) window[i] = '0;
      frame_pos    = '0;
      view_top     = '0;
      mismatches   = 0;
      results_seen = 0;
      bins_seen    = 0;
      frames_seen  = 0;
    endfunction

    function void set_view_top(logic signed [15:0] value);
      view_top = value;
    endfunction

    function int pending();
      return smoothed_due.size();
    endfunction

    function longint tap(int idx);
      return longint'(window[idx]);
    endfunction

    // Division rounding toward minus infinity for a positive divisor.
    function longint floor_quot(longint x, longint d);
      if (x >= 0) return x / d;
      return -((-x + d - 1) / d);
    endfunction

    // Smoothed value of bin d while the newest bin in the window sits at p.
    function logic signed [15:0] blend_bin(int d, int p);
      int     lo;
      int     hi;
      int     ctr;
      longint c;
      longint mx;
      longint mn;
      longint v;
      longint t;
      longint span;
      longint q1;
      longint q2;
      longint q;
      longint s;
      longint k;
      longint r;
      lo  = (d >= 2) ? d - 2 : 0;
      hi  = (d + 2 <= p) ? d + 2 : p;
      ctr = 4 - (p - d);
      c   = tap(ctr);
      mx  = c;
      mn  = c;
      for (int j = lo; j <= hi; j++) begin
        v = tap(4 - (p - j));
        if (v > mx) mx = v;
        if (v < mn) mn = v;
      end
      span = mx - mn;
      t    = longint'(view_top) - VIEW_OFFSET - mx;
      q1   = 0;
      q2   = 0;
      if (t > 0) q1 = (t >= T_SAT) ? Q_ONE : (t * Q_ONE) / T_SAT;
      if (span < SPAN_QUIET) q2 = ((SPAN_QUIET - span) * Q_ONE) / SPAN_QUIET;
      q = (q1 > q2) ? q1 : q2;
      // A weight at or under one thousandth leaves the bin as it is.
      if (q * 1000 <= Q_ONE) return c[15:0];
      if (d >= 2 && d + 2 <= p) begin
        s = tap(ctr - 2) + 2 * tap(ctr - 1) + 4 * c + 2 * tap(ctr + 1) + tap(ctr + 2);
        k = 10;
      end else if (d >= 1 && d + 1 <= p) begin
        s = tap(ctr - 1) + 2 * c + tap(ctr + 1);
        k = 4;
      end else begin
        // The two end bins of a frame are never blended.
        return c[15:0];
      end
      r = c + floor_quot((s - k * c) * q + k * 32768, k * 65536);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
    endfunction

    function void push_result(logic signed [15:0] value, logic last);
      aqss_out_t r;
      r.smoothed_db = value;
      r.out_last    = last;
      smoothed_due.push_back(r);
    endfunction

    // Called for every accepted input beat.
    function void note_bin(aqss_in_t item);
      int p;
      bit closing;
      p       = int'(frame_pos);
      // The bin at the last allowed position closes the frame on its own.
      closing = item.frame_last || (p + 1 >= MAX_BINS);
      for (int i = 0; i < 4; i++) window[i] = window[i + 1];
      window[4] = item.bin_db;
      bins_seen++;
      if (p >= 2) push_result(blend_bin(p - 2, p), 1'b0);
      if (closing) begin
        if (p >= 1) push_result(blend_bin(p - 1, p), 1'b0);
        push_result(blend_bin(p, p), 1'b1);
        frame_pos = '0;
        frames_seen++;
      end else begin
        frame_pos = frame_pos + 1'b1;
      end
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] mismatch on result %0d: %s", $realtime, results_seen, what);
    endtask

    // Called for every accepted output beat.
    task check_result(aqss_out_t got);
      aqss_out_t want;
      if (smoothed_due.size() == 0) begin
        report_mismatch($sformatf("unexpected beat, smoothed_db %0d out_last %0b",
                                  got.smoothed_db, got.out_last));
        return;
      end
      want = smoothed_due.pop_front();
      if (got.smoothed_db !== want.smoothed_db)
        report_mismatch($sformatf("smoothed_db %0d, predicted %0d",
                                  got.smoothed_db, want.smoothed_db));
      if (got.out_last !== want.out_last)
        report_mismatch($sformatf("out_last %0b, predicted %0b",
                                  got.out_last, want.out_last));
      results_seen++;
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  aqss_in_t           in_data;
  logic               out_valid;
  logic               out_ready;
  aqss_out_t          out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic signed [15:0] cfg_data;

  smoother_scoreboard sb = new();

  bit calm_run      = 1'b0;
  int hold_requests = 0;
  int holds_served  = 0;
  int cfg_writes    = 0;
  int quiet_cycles  = 0;

  // Directed bins: single-bin frame, two-bin frame, extremes, a quiet
  // stretch, then a frame pinned at the bottom of the range.
  localparam logic signed [15:0] DIRECTED_BINS [20] = '{
    16'sd32767,
    -16'sd32768, 16'sd32767,
    -16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1,
    -16'sd12000, -16'sd11800, -16'sd12100, -16'sd11950, -16'sd12050,
    -16'sd11900, -16'sd12000,
    -16'sd32768, -16'sd32767, -16'sd32760, -16'sd32768, -16'sd32765
  };
  localparam logic [19:0] DIRECTED_LAST = 20'b1010_0001_0000_0010_0001;

  adaptive_quiet_spectrum_smoother dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Output beats are checked at the rising edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  // Receiver ready: random stalls, one long hold-off on request, none at the end.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else if (calm_run) begin
        out_ready = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready = 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_ready  = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Watchdog on cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               STALL_LIMIT, sb.pending());
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one bin and hold it until the beat is taken.
  task automatic send_bin(input logic signed [15:0] value, input logic last);
    @(negedge clk);
    in_data.bin_db     = value;
    in_data.frame_last = last;
    in_valid           = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_bin(in_data);
  endtask

  task automatic pause_input(input int cycles);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic maybe_gap();
    if (!calm_run && $urandom_range(0, 7) == 0) pause_input($urandom_range(1, 19));
  endtask

  // Stop offering input and wait for every predicted result.
  task automatic drain();
    pause_input(1);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_view_top(input logic signed [15:0] value);
    drain();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_data  = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_view_top(value);
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic signed [15:0] make_bin(input bin_mix_t mix, input int base);
    int v;
    bin_mix_t pick;
    pick = mix;
    if (pick == MIX_ANY) pick = bin_mix_t'($urandom_range(0, 2));
    case (pick)
      MIX_QUIET: v = base + int'($urandom_range(0, 3583));
      MIX_NEAR:  v = base + int'($urandom_range(0, 12000)) - 6000;
      default:   v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Pick a content base that lands near the interesting weight regions.
  function automatic int pick_base(input bin_mix_t mix);
    if (mix == MIX_NEAR) return int'(sb.view_top) - VIEW_OFFSET - int'($urandom_range(0, 9000));
    return int'($urandom_range(0, 65535)) - 32768 - 1800;
  endfunction

  // A frame of random bins; an open frame carries no closing flag.
  task automatic send_frame(input int len, input bin_mix_t mix, input bit closed);
    int base;
    base = pick_base(mix);
    for (int i = 0; i < len; i++) begin
      maybe_gap();
      send_bin(make_bin(mix, base), closed && (i == len - 1));
    end
  endtask

  // Main sequence.
  initial begin
    int sent;
    int len;
    bin_mix_t mix;
    bit closed;
    logic signed [15:0] top;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed frames; the last one runs with the view top at its maximum.
    for (int i = 0; i < 20; i++) begin
      if (i == 15) write_view_top(16'sd32767);
      maybe_gap();
      send_bin(DIRECTED_BINS[i], DIRECTED_LAST[19 - i]);
    end

    // Random phases, each under its own view top.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       top = -16'sd32768;
        2:       top = 16'sd32767;
        3:       top = -16'sd2000;
        default: top = 16'($urandom_range(0, 65535));
      endcase
      write_view_top(top);
      if (ph == 4) calm_run = 1'b1;
      // Long receiver hold-off while input keeps coming.
      if (ph == 1) hold_requests++;
      sent = 0;
      while (sent < PHASE_BINS) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        case ($urandom_range(0, 3))
          0:       mix = MIX_FULL;
          1:       mix = MIX_NEAR;
          2:       mix = MIX_ANY;
          default: mix = MIX_QUIET;
        endcase
        // Sometimes leave the frame open so the next write lands mid-frame.
        closed = !((sent + len >= PHASE_BINS) && ph < 4 && $urandom_range(0, 3) == 0);
        send_frame(len, mix, closed);
        sent += len;
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d bins in %0d closed frames, %0d results checked, %0d register writes",
             sb.bins_seen, sb.frames_seen, sb.results_seen, cfg_writes);
    $display("mismatches found: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
